### hdl/m65lt_pkg.sv
package m65lt_pkg;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] addr;
    logic [7:0]  wdata;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  rdata;
    logic [7:0]  acc;
    logic [7:0]  index_x;
    logic [7:0]  index_y;
    logic [15:0] prog_counter;
    logic [7:0]  stack_ptr;
    logic [7:0]  status;
    logic [2:0]  cycles_used;
    logic        bad_opcode;
  } out_item_t;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_RESET = 2'd2;
  localparam logic [1:0] OP_STEP  = 2'd3;

  localparam logic [15:0] RESET_PC   = 16'hFFFC;
  localparam logic [7:0]  STACK_PAGE = 8'h01;

  // destination register of a load or transfer
  localparam logic [1:0] DST_NONE = 2'd0;
  localparam logic [1:0] DST_A    = 2'd1;
  localparam logic [1:0] DST_X    = 2'd2;
  localparam logic [1:0] DST_Y    = 2'd3;

  // addressing mode
  localparam logic [3:0] AM_IMM  = 4'd0;
  localparam logic [3:0] AM_ZP   = 4'd1;
  localparam logic [3:0] AM_ZPX  = 4'd2;
  localparam logic [3:0] AM_ZPY  = 4'd3;
  localparam logic [3:0] AM_ABS  = 4'd4;
  localparam logic [3:0] AM_ABSX = 4'd5;
  localparam logic [3:0] AM_ABSY = 4'd6;
  localparam logic [3:0] AM_INDX = 4'd7;
  localparam logic [3:0] AM_INDY = 4'd8;
  localparam logic [3:0] AM_JSR  = 4'd9;
  localparam logic [3:0] AM_RTS  = 4'd10;
  localparam logic [3:0] AM_IMPL = 4'd11;
  localparam logic [3:0] AM_BAD  = 4'd12;

  // implied operations
  localparam logic [3:0] IM_SEC = 4'd0;
  localparam logic [3:0] IM_SED = 4'd1;
  localparam logic [3:0] IM_SEI = 4'd2;
  localparam logic [3:0] IM_TAX = 4'd3;
  localparam logic [3:0] IM_TAY = 4'd4;
  localparam logic [3:0] IM_TXA = 4'd5;
  localparam logic [3:0] IM_TYA = 4'd6;
  localparam logic [3:0] IM_TSX = 4'd7;
  localparam logic [3:0] IM_TXS = 4'd8;

  typedef struct packed {
    logic [3:0] mode;
    logic [1:0] dst;
    logic [3:0] impl;
  } decode_t;

  function automatic decode_t decode(input logic [7:0] opc);
    decode_t d;
    d = '{mode: AM_BAD, dst: DST_NONE, impl: IM_SEC};
    case (opc)
      8'hA9: d = '{AM_IMM,  DST_A, IM_SEC};
      8'hA5: d = '{AM_ZP,   DST_A, IM_SEC};
      8'hB5: d = '{AM_ZPX,  DST_A, IM_SEC};
      8'hAD: d = '{AM_ABS,  DST_A, IM_SEC};
      8'hBD: d = '{AM_ABSX, DST_A, IM_SEC};
      8'hB9: d = '{AM_ABSY, DST_A, IM_SEC};
      8'hA1: d = '{AM_INDX, DST_A, IM_SEC};
      8'hB1: d = '{AM_INDY, DST_A, IM_SEC};
      8'hA2: d = '{AM_IMM,  DST_X, IM_SEC};
      8'hA6: d = '{AM_ZP,   DST_X, IM_SEC};
      8'hB6: d = '{AM_ZPY,  DST_X, IM_SEC};
      8'hAE: d = '{AM_ABS,  DST_X, IM_SEC};
      8'hBE: d = '{AM_ABSY, DST_X, IM_SEC};
      8'hA0: d = '{AM_IMM,  DST_Y, IM_SEC};
      8'hA4: d = '{AM_ZP,   DST_Y, IM_SEC};
      8'hB4: d = '{AM_ZPX,  DST_Y, IM_SEC};
      8'hAC: d = '{AM_ABS,  DST_Y, IM_SEC};
      8'hBC: d = '{AM_ABSX, DST_Y, IM_SEC};
      8'h20: d = '{AM_JSR,  DST_NONE, IM_SEC};
      8'h60: d = '{AM_RTS,  DST_NONE, IM_SEC};
      8'h38: d = '{AM_IMPL, DST_NONE, IM_SEC};
      8'hF8: d = '{AM_IMPL, DST_NONE, IM_SED};
      8'h78: d = '{AM_IMPL, DST_NONE, IM_SEI};
      8'hAA: d = '{AM_IMPL, DST_X, IM_TAX};
      8'hA8: d = '{AM_IMPL, DST_Y, IM_TAY};
      8'h8A: d = '{AM_IMPL, DST_A, IM_TXA};
      8'h98: d = '{AM_IMPL, DST_A, IM_TYA};
      8'hBA: d = '{AM_IMPL, DST_X, IM_TSX};
      8'h9A: d = '{AM_IMPL, DST_NONE, IM_TXS};
      default: d = '{AM_BAD, DST_NONE, IM_SEC};
    endcase
    return d;
  endfunction

endpackage

### hdl/mos6502_load_transfer_core.sv
// channel   direction  handshake            payload
// in        input      in_valid_i/in_ready_o   m65lt_pkg::in_item_t
// out       output     out_valid_o/out_ready_i m65lt_pkg::out_item_t
//
// one item at a time through a single memory port with registered read;
// each memory access presents the address, then takes the data from the
// registered read port.
// after reset, and after a reset item, memory is cleared one byte a cycle;
// no item is taken while it clears.
// the result sits in an output register; a new item is taken once it is gone.
module mos6502_load_transfer_core #(
  parameter int MEM_ADDR_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  m65lt_pkg::in_item_t    in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output m65lt_pkg::out_item_t   out_data_o
);
  import m65lt_pkg::*;

  localparam int AW = MEM_ADDR_BITS;

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_RADDR = 8'b0000_0100,
    S_RDATA = 8'b0000_1000,
    S_EXEC  = 8'b0001_0000,
    S_WRITE = 8'b0010_0000,
    S_DONE  = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_e;

  state_e      state_q, state_d;
  logic [AW:0] clr_q, clr_d;
  logic [7:0]  a_q, a_d, x_q, x_d, y_q, y_d, sp_q, sp_d, p_q, p_d;
  logic [15:0] pc_q, pc_d;
  logic [15:0] ma_q, ma_d;   // memory address for pending access
  logic [15:0] tmp_q, tmp_d; // operand / pointer word
  logic [7:0]  opc_q, opc_d;
  logic [2:0]  ph_q, ph_d;   // access number within instruction
  logic [1:0]  op_q, op_d;
  logic [7:0]  wd_q, wd_d;
  logic [7:0]  rb_q, rb_d;
  logic        step_q, step_d;
  logic [2:0]  cyc_q, cyc_d;
  logic        bad_q, bad_d;
  out_item_t   res_q, res_d;

  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_wdata, ram_rdata;

  m65lt_ram #(.Width(8), .Depth(2 ** AW)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  decode_t     dec;
  logic [15:0] sum16;
  logic [7:0]  ld_val;

  assign dec = decode(opc_q);
  // shared address adder
  assign sum16 = tmp_q + {8'h00, (dec.mode == AM_ABSX || dec.mode == AM_ZPX ||
                                  dec.mode == AM_INDX) ? x_q : y_q};

  always_comb begin
    state_d = state_q;
    clr_d = clr_q;
    a_d = a_q; x_d = x_q; y_d = y_q; sp_d = sp_q; p_d = p_q; pc_d = pc_q;
    ma_d = ma_q; tmp_d = tmp_q; opc_d = opc_q; ph_d = ph_q; op_d = op_q;
    wd_d = wd_q; rb_d = rb_q; step_d = step_q; cyc_d = cyc_q; bad_d = bad_q;
    res_d = res_q;
    ram_we = 1'b0;
    ram_addr = ma_q[AW-1:0];
    ram_wdata = wd_q;
    ld_val = ram_rdata;

    case (state_q)
      S_CLEAR: begin
        ram_we = 1'b1;
        ram_addr = clr_q[AW-1:0];
        ram_wdata = 8'h00;
        clr_d = clr_q + 1'b1;
        if (clr_q[AW]) begin
          state_d = step_q ? S_DONE : S_IDLE;
          clr_d = '0;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          op_d = in_data_i.op;
          ma_d = in_data_i.addr;
          wd_d = in_data_i.wdata;
          rb_d = 8'h00;
          step_d = 1'b0;
          cyc_d = 3'd0;
          bad_d = 1'b0;
          case (in_data_i.op)
            OP_WRITE: state_d = S_WRITE;
            OP_READ:  state_d = S_RADDR;
            OP_RESET: begin
              a_d = '0; x_d = '0; y_d = '0; sp_d = '0; p_d = '0;
              pc_d = RESET_PC;
              clr_d = '0;
              step_d = 1'b1; // marks: go to result after clear
              state_d = S_CLEAR;
            end
            default: begin
              ma_d = pc_q;
              pc_d = pc_q + 16'd1;
              ph_d = 3'd0;
              state_d = S_RADDR;
            end
          endcase
        end
      end
      S_WRITE: begin
        ram_we = 1'b1;
        state_d = S_DONE;
      end
      S_RADDR: state_d = S_RDATA; // address presented, data next cycle
      S_RDATA: begin
        if (op_q == OP_READ) begin
          rb_d = ram_rdata;
          state_d = S_DONE;
        end else begin
          state_d = S_RADDR;
          if (ph_q == 3'd0) begin
            opc_d = ram_rdata;
            ph_d = 3'd1;
            state_d = S_EXEC;
          end else begin
            ph_d = ph_q + 3'd1;
            state_d = S_EXEC;
            tmp_d = tmp_q;
            // byte arrives in ram_rdata; handled in exec via rb
            rb_d = ram_rdata;
          end
        end
      end
      S_EXEC: begin
        // ph_q counts accesses done; rb_q holds the latest byte
        state_d = S_RADDR;
        case (dec.mode)
          AM_IMM: begin
            if (ph_q == 3'd1) begin
              ma_d = pc_q; pc_d = pc_q + 16'd1;
            end else begin
              ld_val = rb_q; state_d = S_DONE; cyc_d = 3'd2;
            end
          end
          AM_ZP, AM_ZPX, AM_ZPY: begin
            case (ph_q)
              3'd1: begin ma_d = pc_q; pc_d = pc_q + 16'd1; end
              3'd2: begin
                tmp_d = {8'h00, rb_q};
                ma_d = (dec.mode == AM_ZP) ? {8'h00, rb_q} :
                       {8'h00, rb_q + ((dec.mode == AM_ZPX) ? x_q : y_q)};
              end
              default: begin
                ld_val = rb_q; state_d = S_DONE;
                cyc_d = (dec.mode == AM_ZP) ? 3'd3 : 3'd4;
              end
            endcase
          end
          AM_ABS, AM_ABSX, AM_ABSY: begin
            case (ph_q)
              3'd1: begin ma_d = pc_q; pc_d = pc_q + 16'd1; end
              3'd2: begin tmp_d = {8'h00, rb_q}; ma_d = pc_q; pc_d = pc_q + 16'd1; end
              3'd3: begin
                tmp_d = {rb_q, tmp_q[7:0]};
                ph_d = 3'd3;
                state_d = S_EXEC;
                ph_d = 3'd4;
              end
              3'd4: begin
                ma_d = (dec.mode == AM_ABS) ? tmp_q : sum16;
                cyc_d = (dec.mode != AM_ABS && sum16[15:8] != tmp_q[15:8]) ? 3'd5 : 3'd4;
              end
              default: begin ld_val = rb_q; state_d = S_DONE; end
            endcase
          end
          AM_INDX, AM_INDY: begin
            case (ph_q)
              3'd1: begin ma_d = pc_q; pc_d = pc_q + 16'd1; end
              3'd2: begin
                tmp_d = {8'h00, (dec.mode == AM_INDX) ? rb_q + x_q : rb_q};
                ma_d = {8'h00, (dec.mode == AM_INDX) ? rb_q + x_q : rb_q};
              end
              3'd3: begin
                tmp_d = {tmp_q[7:0], rb_q}; // keep zp in high, lo in low
                ma_d = {8'h00, tmp_q[7:0] + 8'd1};
              end
              3'd4: begin
                tmp_d = {rb_q, tmp_q[7:0]};
                state_d = S_EXEC;
                ph_d = 3'd5;
              end
              3'd5: begin
                ma_d = (dec.mode == AM_INDX) ? tmp_q : sum16;
                cyc_d = (dec.mode == AM_INDY && sum16[15:8] != tmp_q[15:8]) ? 3'd6 :
                        (dec.mode == AM_INDY) ? 3'd5 : 3'd6;
                ph_d = 3'd5;
              end
              default: begin ld_val = rb_q; state_d = S_DONE; end
            endcase
            if (ph_q == 3'd5 && state_d == S_RADDR) ph_d = 3'd6;
          end
          AM_JSR: begin
            case (ph_q)
              3'd1: begin ma_d = pc_q; pc_d = pc_q + 16'd1; end
              3'd2: begin tmp_d = {8'h00, rb_q}; ma_d = pc_q; end
              default: begin
                // pc_q is address of high byte = return address - 1 target
                tmp_d = {rb_q, tmp_q[7:0]};
                ma_d = {STACK_PAGE, sp_q};
                wd_d = pc_q[15:8];
                state_d = S_WRITE;
                ph_d = 3'd0;
                opc_d = opc_q;
              end
            endcase
          end
          AM_RTS: begin
            case (ph_q)
              3'd1: begin ma_d = {STACK_PAGE, sp_q + 8'd1}; sp_d = sp_q + 8'd1; end
              3'd2: begin
                tmp_d = {8'h00, rb_q};
                ma_d = {STACK_PAGE, sp_q + 8'd1}; sp_d = sp_q + 8'd1;
              end
              default: begin
                pc_d = {rb_q, tmp_q[7:0]} + 16'd1;
                cyc_d = 3'd6; state_d = S_DONE;
              end
            endcase
          end
          AM_IMPL: begin
            cyc_d = 3'd2; state_d = S_DONE;
            case (dec.impl)
              IM_SEC: p_d[0] = 1'b1;
              IM_SED: p_d[3] = 1'b1;
              IM_SEI: p_d[2] = 1'b1;
              IM_TAX, IM_TAY: ld_val = a_q;
              IM_TXA, IM_TXS: ld_val = x_q;
              IM_TYA: ld_val = y_q;
              IM_TSX: ld_val = sp_q;
              default: ld_val = a_q;
            endcase
            if (dec.impl == IM_TXS) sp_d = x_q;
          end
          default: begin
            pc_d = pc_q + 16'd1; cyc_d = 3'd1; bad_d = 1'b1; state_d = S_DONE;
          end
        endcase
        if (state_d == S_DONE && dec.dst != DST_NONE) begin
          case (dec.dst)
            DST_A: a_d = ld_val;
            DST_X: x_d = ld_val;
            default: y_d = ld_val;
          endcase
          p_d[1] = (ld_val == 8'h00);
          p_d[7] = ld_val[7];
        end
        if (state_d == S_WRITE) step_d = 1'b1;
      end
      S_DONE: begin
        res_d.rdata = rb_q;
        if (op_q != OP_READ) res_d.rdata = 8'h00;
        res_d.acc = a_q;
        res_d.index_x = x_q;
        res_d.index_y = y_q;
        res_d.prog_counter = pc_q;
        res_d.stack_ptr = sp_q;
        res_d.status = p_q | 8'h20;
        res_d.cycles_used = cyc_q;
        res_d.bad_opcode = bad_q;
        step_d = 1'b0;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase

    // jsr stack writes: two pushes then done
    if (state_q == S_WRITE && op_q == OP_STEP) begin
      if (ph_q == 3'd0) begin
        ma_d = {STACK_PAGE, sp_q - 8'd1};
        wd_d = pc_q[7:0];
        sp_d = sp_q - 8'd1;
        ph_d = 3'd1;
        state_d = S_WRITE;
      end else begin
        sp_d = sp_q - 8'd1;
        pc_d = tmp_q;
        cyc_d = 3'd6;
        state_d = S_DONE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q <= '0;
      a_q <= '0; x_q <= '0; y_q <= '0; sp_q <= '0; p_q <= '0;
      pc_q <= RESET_PC;
      step_q <= 1'b0;
      op_q <= OP_WRITE;
      ph_q <= '0;
    end else begin
      state_q <= state_d;
      clr_q <= clr_d;
      a_q <= a_d; x_q <= x_d; y_q <= y_d; sp_q <= sp_d; p_q <= p_d;
      pc_q <= pc_d;
      step_q <= step_d;
      op_q <= op_d;
      ph_q <= ph_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ma_q <= ma_d; tmp_q <= tmp_d; opc_q <= opc_d; wd_q <= wd_d; rb_q <= rb_d;
    cyc_q <= cyc_d; bad_q <= bad_d; res_q <= res_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign out_data_o  = res_q;

endmodule

### hdl/m65lt_ram.sv
module m65lt_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

### sim/tb_mos6502_load_transfer_core.sv
module tb_mos6502_load_transfer_core;
  import m65lt_pkg::*;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_item_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_data_o;

  mos6502_load_transfer_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  localparam logic [7:0] FLAG_C = 8'h01;
  localparam logic [7:0] FLAG_Z = 8'h02;
  localparam logic [7:0] FLAG_I = 8'h04;
  localparam logic [7:0] FLAG_D = 8'h08;
  localparam logic [7:0] FLAG_N = 8'h80;
  localparam logic [7:0] FLAG_ONE = 8'h20;

  localparam logic [7:0] OPCODES [29] = '{
    8'hA9, 8'hA5, 8'hB5, 8'hAD, 8'hBD, 8'hB9, 8'hA1, 8'hB1, 8'hA2, 8'hA6,
    8'hB6, 8'hAE, 8'hBE, 8'hA0, 8'hA4, 8'hB4, 8'hAC, 8'hBC, 8'h20, 8'h60,
    8'h38, 8'hF8, 8'h78, 8'hAA, 8'hA8, 8'h8A, 8'h98, 8'hBA, 8'h9A};

  // shadow cpu state
  logic [7:0]  shadow_mem [0:65535];
  logic [7:0]  cpu_a, cpu_x, cpu_y, cpu_sp, cpu_flags;
  logic [15:0] cpu_pc;

  in_item_t  pending_q [$];
  out_item_t result_q [$];
  int        n_items = 0;
  int        n_sent = 0;
  int        n_rcvd = 0;
  int        n_errors = 0;
  int        hold_cnt = 0;
  bit        hold_done = 1'b0;

  function automatic void cpu_clear();
    for (int i = 0; i < 65536; i++) shadow_mem[i] = 8'h00;
    cpu_a = 8'h00;
    cpu_x = 8'h00;
    cpu_y = 8'h00;
    cpu_pc = RESET_PC;
    cpu_sp = 8'h00;
    cpu_flags = 8'h00;
  endfunction

  function automatic logic [7:0] fetch_byte();
    logic [7:0] v;
    v = shadow_mem[cpu_pc];
    cpu_pc = cpu_pc + 16'd1;
    return v;
  endfunction

  function automatic logic [15:0] fetch_word();
    logic [7:0] lo;
    logic [7:0] hi;
    lo = fetch_byte();
    hi = fetch_byte();
    return {hi, lo};
  endfunction

  // pointer fetch wraps within page zero
  function automatic logic [15:0] zp_pointer(logic [7:0] zp);
    logic [7:0] nxt;
    nxt = zp + 8'd1;
    return {shadow_mem[nxt], shadow_mem[zp]};
  endfunction

  function automatic logic [7:0] load_nz(logic [7:0] v);
    cpu_flags = cpu_flags & ~(FLAG_N | FLAG_Z);
    if (v == 8'h00) cpu_flags = cpu_flags | FLAG_Z;
    if (v[7]) cpu_flags = cpu_flags | FLAG_N;
    return v;
  endfunction

  function automatic logic [7:0] zp_idx(logic [7:0] idx);
    logic [7:0] zp;
    zp = fetch_byte() + idx;
    return shadow_mem[zp];
  endfunction

  function automatic logic [7:0] abs_idx(logic [7:0] idx, inout int cyc);
    logic [15:0] base;
    logic [15:0] ea;
    base = fetch_word();
    ea = base + {8'h00, idx};
    if (base[15:8] != ea[15:8]) cyc++;
    return shadow_mem[ea];
  endfunction

  function automatic void stack_push(logic [7:0] v);
    shadow_mem[{STACK_PAGE, cpu_sp}] = v;
    cpu_sp = cpu_sp - 8'd1;
  endfunction

  function automatic logic [7:0] stack_pull();
    cpu_sp = cpu_sp + 8'd1;
    return shadow_mem[{STACK_PAGE, cpu_sp}];
  endfunction

  function automatic int exec_instr(output logic bad);
    logic [7:0]  opc;
    logic [7:0]  lo;
    logic [7:0]  hi;
    logic [15:0] ptr;
    logic [15:0] ea;
    int          cyc;
    bad = 1'b0;
    cyc = 4;
    opc = fetch_byte();
    case (opc)
      8'hA9: begin cpu_a = load_nz(fetch_byte()); return 2; end
      8'hA5: begin cpu_a = load_nz(shadow_mem[fetch_byte()]); return 3; end
      8'hB5: begin cpu_a = load_nz(zp_idx(cpu_x)); return 4; end
      8'hAD: begin cpu_a = load_nz(shadow_mem[fetch_word()]); return 4; end
      8'hBD: begin cpu_a = load_nz(abs_idx(cpu_x, cyc)); return cyc; end
      8'hB9: begin cpu_a = load_nz(abs_idx(cpu_y, cyc)); return cyc; end
      8'hA1: begin
        lo = fetch_byte() + cpu_x;
        cpu_a = load_nz(shadow_mem[zp_pointer(lo)]);
        return 6;
      end
      8'hB1: begin
        ptr = zp_pointer(fetch_byte());
        ea = ptr + {8'h00, cpu_y};
        cyc = (ptr[15:8] != ea[15:8]) ? 6 : 5;
        cpu_a = load_nz(shadow_mem[ea]);
        return cyc;
      end
      8'hA2: begin cpu_x = load_nz(fetch_byte()); return 2; end
      8'hA6: begin cpu_x = load_nz(shadow_mem[fetch_byte()]); return 3; end
      8'hB6: begin cpu_x = load_nz(zp_idx(cpu_y)); return 4; end
      8'hAE: begin cpu_x = load_nz(shadow_mem[fetch_word()]); return 4; end
      8'hBE: begin cpu_x = load_nz(abs_idx(cpu_y, cyc)); return cyc; end
      8'hA0: begin cpu_y = load_nz(fetch_byte()); return 2; end
      8'hA4: begin cpu_y = load_nz(shadow_mem[fetch_byte()]); return 3; end
      8'hB4: begin cpu_y = load_nz(zp_idx(cpu_x)); return 4; end
      8'hAC: begin cpu_y = load_nz(shadow_mem[fetch_word()]); return 4; end
      8'hBC: begin cpu_y = load_nz(abs_idx(cpu_x, cyc)); return cyc; end
      8'h20: begin
        ptr = fetch_word();
        ea = cpu_pc - 16'd1;
        stack_push(ea[15:8]);
        stack_push(ea[7:0]);
        cpu_pc = ptr;
        return 6;
      end
      8'h60: begin
        lo = stack_pull();
        hi = stack_pull();
        cpu_pc = {hi, lo} + 16'd1;
        return 6;
      end
      8'h38: begin cpu_flags = cpu_flags | FLAG_C; return 2; end
      8'hF8: begin cpu_flags = cpu_flags | FLAG_D; return 2; end
      8'h78: begin cpu_flags = cpu_flags | FLAG_I; return 2; end
      8'hAA: begin cpu_x = load_nz(cpu_a); return 2; end
      8'hA8: begin cpu_y = load_nz(cpu_a); return 2; end
      8'h8A: begin cpu_a = load_nz(cpu_x); return 2; end
      8'h98: begin cpu_a = load_nz(cpu_y); return 2; end
      8'hBA: begin cpu_x = load_nz(cpu_sp); return 2; end
      8'h9A: begin cpu_sp = cpu_x; return 2; end
      default: begin
        // unknown opcode skips one extra byte
        cpu_pc = cpu_pc + 16'd1;
        bad = 1'b1;
        return 1;
      end
    endcase
  endfunction

  function automatic out_item_t predict_result(in_item_t it);
    out_item_t r;
    logic      bad;
    int        cyc;
    r = '0;
    bad = 1'b0;
    cyc = 0;
    case (it.op)
      OP_WRITE: shadow_mem[it.addr] = it.wdata;
      OP_READ:  r.rdata = shadow_mem[it.addr];
      OP_RESET: cpu_clear();
      OP_STEP:  cyc = exec_instr(bad);
      default: ;
    endcase
    r.acc = cpu_a;
    r.index_x = cpu_x;
    r.index_y = cpu_y;
    r.prog_counter = cpu_pc;
    r.stack_ptr = cpu_sp;
    r.status = cpu_flags | FLAG_ONE;
    r.cycles_used = cyc[2:0];
    r.bad_opcode = bad;
    return r;
  endfunction

  task automatic add_item(logic [1:0] op, logic [15:0] addr, logic [7:0] wdata);
    in_item_t it;
    it.op = op;
    it.addr = addr;
    it.wdata = wdata;
    result_q.push_back(predict_result(it));
    pending_q.push_back(it);
    n_items++;
  endtask

  // places one instruction at the pc, may seed its operand data, then steps it and may read back
  task automatic add_instr(logic [7:0] opc);
    logic [15:0] at;
    logic [15:0] ea;
    logic [7:0]  o1;
    logic [7:0]  o2;
    logic [7:0]  zp;
    bit          seed;
    at = cpu_pc;
    o1 = 8'($urandom);
    o2 = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(3));
    add_item(OP_WRITE, at, opc);
    add_item(OP_WRITE, at + 16'd1, o1);
    add_item(OP_WRITE, at + 16'd2, o2);
    seed = 1'b1;
    ea = '0;
    case (opc)
      8'hA5, 8'hA6, 8'hA4: ea = {8'h00, o1};
      8'hB5, 8'hB4: ea = {8'h00, 8'(o1 + cpu_x)};
      8'hB6: ea = {8'h00, 8'(o1 + cpu_y)};
      8'hAD, 8'hAE, 8'hAC: ea = {o2, o1};
      8'hBD, 8'hBC: ea = {o2, o1} + {8'h00, cpu_x};
      8'hB9, 8'hBE: ea = {o2, o1} + {8'h00, cpu_y};
      8'hA1, 8'hB1: begin
        zp = (opc == 8'hA1) ? 8'(o1 + cpu_x) : o1;
        add_item(OP_WRITE, {8'h00, zp}, 8'($urandom));
        add_item(OP_WRITE, {8'h00, 8'(zp + 8'd1)}, 8'($urandom_range(3)));
        seed = 1'b0;
      end
      default: seed = 1'b0;
    endcase
    if (seed && $urandom_range(3) != 0) add_item(OP_WRITE, ea, 8'($urandom));
    add_item(OP_STEP, 16'($urandom), 8'($urandom));
    if ($urandom_range(4) == 0)
      add_item(OP_READ, seed ? ea : 16'($urandom), 8'($urandom));
  endtask

  task automatic report(string what, longint got, longint want);
    n_errors++;
    $display("mismatch %s: got %0h want %0h", what, got, want);
  endtask

  task automatic check_result(out_item_t got);
    out_item_t want;
    if (result_q.size() == 0) begin
      report("unexpected result", 64'(got), 64'(0));
      return;
    end
    want = result_q.pop_front();
    if (got.rdata !== want.rdata) report("rdata", 64'(got.rdata), 64'(want.rdata));
    if (got.acc !== want.acc) report("acc", 64'(got.acc), 64'(want.acc));
    if (got.index_x !== want.index_x)
      report("index_x", 64'(got.index_x), 64'(want.index_x));
    if (got.index_y !== want.index_y)
      report("index_y", 64'(got.index_y), 64'(want.index_y));
    if (got.prog_counter !== want.prog_counter)
      report("prog_counter", 64'(got.prog_counter), 64'(want.prog_counter));
    if (got.stack_ptr !== want.stack_ptr)
      report("stack_ptr", 64'(got.stack_ptr), 64'(want.stack_ptr));
    if (got.status !== want.status) report("status", 64'(got.status), 64'(want.status));
    if (got.cycles_used !== want.cycles_used)
      report("cycles_used", 64'(got.cycles_used), 64'(want.cycles_used));
    if (got.bad_opcode !== want.bad_opcode)
      report("bad_opcode", 64'(got.bad_opcode), 64'(want.bad_opcode));
  endtask

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // sender, with a stretch of back-to-back items in the middle of the run
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_ready_o) begin
      if (in_valid_i) begin
        void'(pending_q.pop_front());
        n_sent++;
      end
      if (pending_q.size() > 0 &&
          ((n_sent > 600 && n_sent < 900) || $urandom_range(99) >= 29)) begin
        in_valid_i <= 1'b1;
        in_data_i <= pending_q[0];
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver, with one long hold-off so the input side backs up
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        check_result(out_data_o);
        n_rcvd++;
      end
      if (!hold_done && n_rcvd == 300) begin
        hold_done <= 1'b1;
        hold_cnt <= 400;
        out_ready_i <= 1'b0;
      end else if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= (n_rcvd > 1000 && n_rcvd < 1300) || $urandom_range(99) >= 29;
      end
    end
  end

  initial begin
    int r;
    cpu_clear();
    // directed: extremes, a reset, flag cases and an unknown opcode
    add_item(OP_WRITE, 16'hFFFF, 8'hFF);
    add_item(OP_READ, 16'hFFFF, 8'h00);
    add_item(OP_READ, 16'h0000, 8'hFF);
    add_item(OP_STEP, 16'h0000, 8'h00);
    add_instr(8'hA9);
    add_item(OP_WRITE, cpu_pc, 8'hA2);
    add_item(OP_WRITE, cpu_pc + 16'd1, 8'h80);
    add_item(OP_STEP, 16'hFFFF, 8'hFF);
    add_item(OP_WRITE, cpu_pc, 8'hA0);
    add_item(OP_WRITE, cpu_pc + 16'd1, 8'h00);
    add_item(OP_STEP, 16'h0000, 8'h00);
    add_instr(8'h20);
    add_instr(8'h60);
    add_item(OP_RESET, 16'hFFFF, 8'hFF);
    add_item(OP_READ, 16'hFFFF, 8'h00);
    while (n_items < 1600) begin
      r = $urandom_range(99);
      if (r < 1) add_item(OP_RESET, 16'($urandom), 8'($urandom));
      else if (r < 7) add_item(OP_WRITE, 16'($urandom), 8'($urandom));
      else if (r < 13) add_item(OP_READ, 16'($urandom), 8'($urandom));
      else if (r < 16) add_item(OP_STEP, 16'($urandom), 8'($urandom));
      else if (r < 20) add_instr(8'($urandom));
      else add_instr(OPCODES[$urandom_range(28)]);
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (pending_q.size() > 0 || in_valid_i || result_q.size() > 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (n_errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #40000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
